// File: src/led_blink_code_serializer_assert.svh
// Assertion macros shared by the blink-code serializer RTL.
// Every macro expects signals named clk and rst_n in the enclosing module.
`ifndef LED_BLINK_CODE_SERIALIZER_ASSERT_SVH
`define LED_BLINK_CODE_SERIALIZER_ASSERT_SVH

// Same-cycle implication, checked out of reset only
`define LBCS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset only
`define LBCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lbcs_pkg.sv
// Shared types and constants for the LED blink-code serializer.
// No dependencies; imported by lbcs_fifo and led_blink_code_serializer.
`timescale 1ns / 1ps

package lbcs_pkg;

    // Fixed field widths
    localparam int CODE_FIELD_W   = 64;
    localparam int TICK_W         = 16;
    localparam int CODE_BITS_W    = 7;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int QUEUED_W       = 4;

    // Parameter defaults
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int CODE_WIDTH_DEF  = 64;

    // Register reset values
    localparam logic [CODE_BITS_W-1:0] CODE_BITS_RST   = 7'd64;
    localparam logic [TICK_W-1:0]      BIT_TICKS_RST   = 16'd200;
    localparam logic [TICK_W-1:0]      PAUSE_TICKS_RST = 16'd1000;
    localparam logic [TICK_W-1:0]      RESUME_TICKS_RST = 16'd1000;

    // Item kinds
    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_SHOW    = 2'd1,
        MODE_SUSPEND = 2'd2
    } mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLED         = 3'd0,
        CFG_SUSPEND_ALLOWED = 3'd1,
        CFG_CODE_BITS       = 3'd2,
        CFG_BIT_TICKS       = 3'd3,
        CFG_PAUSE_TICKS     = 3'd4,
        CFG_RESUME_TICKS    = 3'd5
    } cfg_index_t;

    // Player phases
    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_BIT     = 3'd1,
        PH_RELEASE = 3'd2,
        PH_PAUSE   = 3'd3,
        PH_SUSPEND = 3'd4
    } phase_t;

    // Input item
    typedef struct packed {
        logic [1:0]              mode;
        logic [CODE_FIELD_W-1:0] code;
        logic                    led;
    } item_t;

    // Result item
    typedef struct packed {
        logic                red_level;
        logic                green_level;
        logic                accepted;
        logic                queue_drained;
        logic [QUEUED_W-1:0] queued;
    } result_t;

    // Queue commands from the player
    typedef struct packed {
        logic push;
        logic pop;
    } fifo_cmd_t;

endpackage

// File: src/lbcs_fifo.sv
// Code queue: head register in front of a small memory with registered read.
// Depends on lbcs_pkg and led_blink_code_serializer_assert.svh.
`timescale 1ns / 1ps
`include "led_blink_code_serializer_assert.svh"

module lbcs_fifo import lbcs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CODE_WIDTH  = CODE_WIDTH_DEF,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fifo_cmd_t             cmd,
    input  logic [CODE_WIDTH-1:0] wdata,
    output logic [CODE_WIDTH-1:0] head,
    output logic [CNT_W-1:0]      count
);

    localparam int MEM_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    logic [CODE_WIDTH-1:0] mem_reg [MEM_DEPTH];
    logic [CODE_WIDTH-1:0] head_reg, head_next;
    logic [CODE_WIDTH-1:0] rd_data_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [MEM_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [MEM_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic                  mem_we;

    // Oldest entry lives in head_reg; the rest sit in memory in order.
    // Push and pop never come in the same cycle.
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        mem_we      = 1'b0;
        if (cmd.push)
        begin
            if (count_reg == '0)
            begin
                head_next = wdata;
            end
            else
            begin
                mem_we      = 1'b1;
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            if (count_reg > CNT_W'(1))
            begin
                head_next   = rd_data_reg;
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
            count_next = count_reg - 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // Memory and data path; read data tracks the next read pointer,
    // with a forward of a same-cycle write to that entry.
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        if (mem_we)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
        if (mem_we && (wr_ptr_reg == rd_ptr_next))
        begin
            rd_data_reg <= wdata;
        end
        else
        begin
            rd_data_reg <= mem_reg[rd_ptr_next];
        end
    end

    assign head  = head_reg;
    assign count = count_reg;

    `LBCS_ASSERT_IMPLIES(a_push_room, cmd.push, count_reg < CNT_W'(QUEUE_DEPTH), "push into full queue")
    `LBCS_ASSERT_IMPLIES(a_pop_data, cmd.pop, count_reg != '0, "pop from empty queue")
    `LBCS_ASSERT_IMPLIES(a_one_cmd, cmd.push, !cmd.pop, "push and pop in one cycle")

endmodule

// File: src/led_blink_code_serializer.sv
// Top level of the LED blink-code serializer; depends on lbcs_pkg, lbcs_fifo and the
// assertion macros in led_blink_code_serializer_assert.svh.
// Path: an input transfer goes through the input register, then the result register,
// before the earliest result transfer.
// Throughput: one item per cycle while result_ready holds; both stages refill in the cycle they empty.
// Reset (rst_n, async, active low): registers to reset values, queue empty, player waiting.
`timescale 1ns / 1ps
`include "led_blink_code_serializer_assert.svh"

module led_blink_code_serializer import lbcs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CODE_WIDTH  = CODE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int BL_W  = $clog2(CODE_WIDTH);

    // Configuration registers
    logic                   enabled_reg;
    logic                   suspend_allowed_reg;
    logic [CODE_BITS_W-1:0] code_bits_reg;
    logic [TICK_W-1:0]      bit_ticks_reg;
    logic [TICK_W-1:0]      pause_ticks_reg;
    logic [TICK_W-1:0]      resume_ticks_reg;

    // Pipeline registers
    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_item_reg, out_item_next;
    result_t out_item_comb;
    logic    proc;

    // Player state
    phase_t                phase_reg, phase_next;
    logic [CODE_WIDTH-1:0] shift_reg, shift_next;
    logic [BL_W-1:0]       bits_left_reg, bits_left_next;
    logic [TICK_W-1:0]     timer_reg, timer_next;
    logic                  use_green_reg, use_green_next;
    logic                  susp_reg, susp_next;
    logic                  drained_reg, drained_next;

    // Queue interface
    fifo_cmd_t             fifo_cmd;
    logic [CODE_WIDTH-1:0] fifo_head;
    logic [CNT_W-1:0]      fifo_count;
    logic [CNT_W-1:0]      count_after;

    // Player helpers
    logic [CODE_WIDTH-1:0]  show_code;
    logic [CODE_BITS_W-1:0] code_len;
    logic [BL_W-1:0]        bl_init;
    logic [TICK_W-1:0]      bit_t1, pause_t1, resume_t1;
    logic                   start, between, susp_eff;
    logic [CODE_WIDTH-1:0]  start_data;
    logic                   level;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg         <= 1'b0;
            suspend_allowed_reg <= 1'b0;
            code_bits_reg       <= CODE_BITS_RST;
            bit_ticks_reg       <= BIT_TICKS_RST;
            pause_ticks_reg     <= PAUSE_TICKS_RST;
            resume_ticks_reg    <= RESUME_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLED:         enabled_reg         <= cfg_wdata[0];
                CFG_SUSPEND_ALLOWED: suspend_allowed_reg <= cfg_wdata[0];
                CFG_CODE_BITS:       code_bits_reg       <= cfg_wdata[CODE_BITS_W-1:0];
                CFG_BIT_TICKS:       bit_ticks_reg       <= cfg_wdata;
                CFG_PAUSE_TICKS:     pause_ticks_reg     <= cfg_wdata;
                CFG_RESUME_TICKS:    resume_ticks_reg    <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    // Handshake: input register advances when the result register can take a result
    assign proc          = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready    = !in_valid_reg || proc;
    assign in_valid_next = (item_valid && item_ready) || (in_valid_reg && !proc);
    assign out_valid_next = proc || (out_valid_reg && !result_ready);

    // Derived settings: clamped length and zero-as-one durations
    always_comb
    begin
        if (code_bits_reg == '0)
        begin
            code_len = CODE_BITS_W'(1);
        end
        else if (code_bits_reg > CODE_BITS_W'(CODE_WIDTH))
        begin
            code_len = CODE_BITS_W'(CODE_WIDTH);
        end
        else
        begin
            code_len = code_bits_reg;
        end
    end

    assign bl_init   = BL_W'(code_len - 1'b1);
    assign bit_t1    = (bit_ticks_reg == '0) ? TICK_W'(1) : bit_ticks_reg;
    assign pause_t1  = (pause_ticks_reg == '0) ? TICK_W'(1) : pause_ticks_reg;
    assign resume_t1 = (resume_ticks_reg == '0) ? TICK_W'(1) : resume_ticks_reg;
    assign show_code = {in_item_reg.code[CODE_WIDTH-1:1], in_item_reg.led};
    assign susp_eff  = (phase_reg == PH_SUSPEND) ? 1'b0 : susp_reg;

    // Next state of the player, queue commands and the accepted flag
    always_comb
    begin
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        timer_next     = timer_reg;
        use_green_next = use_green_reg;
        susp_next      = susp_reg;
        drained_next   = drained_reg;
        fifo_cmd       = '0;
        start          = 1'b0;
        start_data     = show_code;
        between        = 1'b0;
        out_item_next  = out_item_reg;
        out_item_next.accepted = 1'b0;

        if (proc)
        begin
            case (in_item_reg.mode)
                MODE_TICK:
                begin
                    if (phase_reg != PH_WAIT)
                    begin
                        if (timer_reg > TICK_W'(1))
                        begin
                            timer_next = timer_reg - 1'b1;
                        end
                        else
                        begin
                            timer_next = '0;
                            case (phase_reg)
                                PH_BIT:
                                begin
                                    shift_next     = {shift_reg[CODE_WIDTH-2:0], 1'b0};
                                    bits_left_next = bits_left_reg - 1'b1;
                                    timer_next     = bit_t1;
                                    if (bits_left_reg == BL_W'(1))
                                    begin
                                        phase_next = PH_RELEASE;
                                    end
                                end
                                PH_RELEASE:
                                begin
                                    drained_next = (fifo_count == '0);
                                    phase_next   = PH_PAUSE;
                                    timer_next   = pause_t1;
                                end
                                PH_PAUSE:
                                begin
                                    between = 1'b1;
                                end
                                PH_SUSPEND:
                                begin
                                    susp_next = 1'b0;
                                    between   = 1'b1;
                                end
                                default:
                                begin
                                    phase_next = PH_WAIT;
                                end
                            endcase
                        end
                    end
                end
                MODE_SHOW:
                begin
                    if (enabled_reg && (fifo_count < CNT_W'(QUEUE_DEPTH)))
                    begin
                        out_item_next.accepted = 1'b1;
                        if ((phase_reg == PH_WAIT) && (fifo_count == '0))
                        begin
                            start = 1'b1;
                        end
                        else
                        begin
                            fifo_cmd.push = 1'b1;
                        end
                    end
                end
                MODE_SUSPEND:
                begin
                    if (suspend_allowed_reg)
                    begin
                        susp_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // Gap between codes: suspend first, then the next queued code
            if (between)
            begin
                if (susp_eff)
                begin
                    phase_next = PH_SUSPEND;
                    timer_next = resume_t1;
                end
                else if (fifo_count != '0)
                begin
                    fifo_cmd.pop = 1'b1;
                    start_data   = fifo_head;
                    start        = 1'b1;
                end
                else
                begin
                    phase_next = PH_WAIT;
                end
            end

            // Load a new code into the player
            if (start)
            begin
                shift_next     = start_data;
                use_green_next = start_data[0];
                bits_left_next = bl_init;
                timer_next     = bit_t1;
                phase_next     = (bl_init != '0) ? PH_BIT : PH_RELEASE;
            end
        end
    end

    // Result fields from the updated state
    assign count_after = fifo_count + CNT_W'(fifo_cmd.push) - CNT_W'(fifo_cmd.pop);
    assign level       = !shift_next[CODE_WIDTH-1];

    always_comb
    begin
        result_t r;
        r = out_item_next;
        if (proc)
        begin
            r.red_level     = 1'b1;
            r.green_level   = 1'b1;
            if (phase_next == PH_BIT)
            begin
                if (use_green_next)
                begin
                    r.green_level = level;
                end
                else
                begin
                    r.red_level = level;
                end
            end
            r.queue_drained = drained_next;
            r.queued        = QUEUED_W'(count_after);
        end
        out_item_comb = r;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_WAIT;
            shift_reg     <= '0;
            bits_left_reg <= '0;
            timer_reg     <= '0;
            use_green_reg <= 1'b0;
            susp_reg      <= 1'b0;
            drained_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            timer_reg     <= timer_next;
            use_green_reg <= use_green_next;
            susp_reg      <= susp_next;
            drained_reg   <= drained_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_item_reg <= item;
        end
        if (proc)
        begin
            out_item_reg <= out_item_comb;
        end
    end

    lbcs_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CODE_WIDTH  (CODE_WIDTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (fifo_cmd),
        .wdata (show_code),
        .head  (fifo_head),
        .count (fifo_count)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    `LBCS_ASSERT_IMPLIES(a_wait_empty, phase_reg == PH_WAIT, fifo_count == '0, "waiting with queued codes")
    `LBCS_ASSERT_IMPLIES(a_bit_left, phase_reg == PH_BIT, bits_left_reg != '0, "showing with no bits left")
    `LBCS_ASSERT_IMPLIES(a_one_pin, result_valid, result.red_level || result.green_level, "both pins lit")

endmodule
